>>> hdl/bms_pkg.sv
// shared types and constants of the band mean and deviation accumulator
package bms_pkg;

	// fixed field and counter widths
	localparam int SP_W   = 12;
	localparam int BP_W   = 6;
	localparam int LC_W   = 17;
	localparam int NB_W   = 7;
	localparam int NS_W   = 13;
	localparam int LBT_W  = 28;
	localparam int PSQ_W  = 44;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 2;

	// op queue depth
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	localparam logic [23:0] Q8_MAX = 24'hFFFFFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_NUM_BANDS   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_NUM_SAMPLES = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_STAT_MODE   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ALIGN = 2'd1,
		ST_OVF   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		AR_MUL  = 2'd0,
		AR_DIV  = 2'd1,
		AR_SQRT = 2'd2
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	// one unit of work from front to back
	typedef struct packed {
		logic              do_acc;
		logic              frame;
		logic [BP_W-1:0]   band;
		logic [LBT_W-1:0]  pix_sum;
		logic [PSQ_W-1:0]  pix_sq;
		logic [LBT_W-1:0]  lbt;
		logic [NS_W-1:0]   ns;
		logic              fin;
		status_t           status;
		logic [NB_W-1:0]   nb;
		logic [LC_W-1:0]   lc;
		logic              mode;
	} op_t;

endpackage

>>> hdl/bms_if.sv
// stream interfaces for pixel input and result output
interface bms_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic        last;
	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface

interface bms_res_if;
	logic        valid;
	logic        ready;
	logic [5:0]  band;
	logic [23:0] mean_q8;
	logic [23:0] std_q8;
	logic [1:0]  status;
	logic        final_res;
	modport source(output valid, output band, output mean_q8, output std_q8,
		output status, output final_res, input ready);
	modport sink(input valid, input band, input mean_q8, input std_q8,
		input status, input final_res, output ready);
endinterface

>>> hdl/bms_front.sv
// front end: position tracking, per-segment accumulation, op generation
module bms_front import bms_pkg::*; #(
	parameter int LINES_MAX = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	bms_pix_if.sink         pix,
	input  logic [NB_W-1:0] nb_eff,
	input  logic [NS_W-1:0] ns_eff,
	input  logic            mode,
	input  logic            q_full,
	output logic            q_push,
	output op_t             q_op
);

	localparam logic [LC_W-1:0] LC_MAX = LC_W'(LINES_MAX);

	logic [SP_W-1:0]  sp_q;
	logic [BP_W-1:0]  bp_q;
	logic [LC_W-1:0]  lc_q;
	logic             ovf_q;
	logic [LBT_W-1:0] pix_sum_q;
	logic [PSQ_W-1:0] pix_sq_q;
	logic [LBT_W-1:0] lbt_q;

	logic             accept;
	logic             active;
	logic [31:0]      vsq;
	logic [LBT_W-1:0] sum_nx;
	logic [PSQ_W-1:0] sq_nx;
	logic [LBT_W-1:0] lbt_nx;
	logic             seg_end;
	logic             line_end;
	logic [LC_W-1:0]  lc_nx;
	logic             ovf_nx;
	status_t          status;

	assign pix.ready = !q_full;
	assign accept    = pix.valid && pix.ready;

	// accumulate the pixel into the running segment
	always_comb begin
		active  = lc_q < LC_MAX;
		vsq     = 32'(pix.value) * 32'(pix.value);
		sum_nx  = pix_sum_q + ((active && !mode) ? LBT_W'(pix.value) : '0);
		sq_nx   = pix_sq_q + ((active && !mode) ? PSQ_W'(vsq) : '0);
		lbt_nx  = lbt_q + ((active && mode) ? LBT_W'(pix.value) : '0);
		seg_end  = ({1'b0, sp_q} + NS_W'(1)) >= ns_eff;
		line_end = seg_end && (({1'b0, bp_q} + NB_W'(1)) >= nb_eff);
		lc_nx  = lc_q;
		ovf_nx = ovf_q;
		if (line_end) begin
			if (active) lc_nx = lc_q + LC_W'(1);
			else ovf_nx = 1'b1;
		end
		if (!line_end) status = ST_ALIGN;
		else if (ovf_nx) status = ST_OVF;
		else status = ST_OK;
	end

	// op toward the back end
	always_comb begin
		q_push         = accept && (seg_end || pix.last);
		q_op.do_acc    = seg_end && (!pix.last || status == ST_OK);
		q_op.frame     = active && mode;
		q_op.band      = bp_q;
		q_op.pix_sum   = sum_nx;
		q_op.pix_sq    = sq_nx;
		q_op.lbt       = lbt_nx;
		q_op.ns        = ns_eff;
		q_op.fin       = pix.last;
		q_op.status    = status;
		q_op.nb        = nb_eff;
		q_op.lc        = lc_nx;
		q_op.mode      = mode;
	end

	// position and segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			bp_q      <= '0;
			lc_q      <= '0;
			ovf_q     <= 1'b0;
			pix_sum_q <= '0;
			pix_sq_q  <= '0;
			lbt_q     <= '0;
		end else if (accept) begin
			if (pix.last) begin
				sp_q      <= '0;
				bp_q      <= '0;
				lc_q      <= '0;
				ovf_q     <= 1'b0;
				pix_sum_q <= '0;
				pix_sq_q  <= '0;
				lbt_q     <= '0;
			end else begin
				lc_q  <= lc_nx;
				ovf_q <= ovf_nx;
				if (seg_end) begin
					sp_q      <= '0;
					pix_sum_q <= '0;
					pix_sq_q  <= '0;
					lbt_q     <= '0;
					bp_q      <= line_end ? '0 : bp_q + BP_W'(1);
				end else begin
					sp_q      <= sp_q + SP_W'(1);
					pix_sum_q <= sum_nx;
					pix_sq_q  <= sq_nx;
					lbt_q     <= lbt_nx;
				end
			end
		end
	end

endmodule

>>> hdl/bms_fifo.sv
// short op queue between front and back
module bms_fifo import bms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  din,
	output logic full,
	input  logic pop,
	output op_t  dout,
	output logic empty
);

	op_t            mem_q [QDEPTH];
	logic [QPW-1:0] wp_q;
	logic [QPW-1:0] rp_q;
	logic [QPW:0]   cnt_q;

	assign full  = cnt_q == (QPW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QPW'(1);
			if (pop) rp_q <= rp_q + QPW'(1);
			cnt_q <= cnt_q + (QPW+1)'(push) - (QPW+1)'(pop);
		end
	end

endmodule

>>> hdl/bms_arith.sv
// shared iterative unit: 64x64 multiply, 64/64 divide, 128-bit square root
module bms_arith import bms_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  arith_cmd_t   cmd,
	input  logic [127:0] a,
	input  logic [63:0]  b,
	output arith_sts_t   sts,
	output logic [127:0] res
);

	logic         busy_q;
	logic         done_q;
	arith_op_t    op_q;
	logic [5:0]   cnt_q;
	logic [127:0] acc_q;
	logic [127:0] x_q;
	logic [63:0]  y_q;
	logic [67:0]  rem_q;

	logic [127:0] acc_nx;
	logic [127:0] x_nx;
	logic [63:0]  y_nx;
	logic [67:0]  rem_nx;
	logic [67:0]  r;
	logic [67:0]  trial;

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = acc_q;

	// one iteration of the selected operation
	always_comb begin
		acc_nx = acc_q;
		x_nx   = x_q;
		y_nx   = y_q;
		rem_nx = rem_q;
		r      = '0;
		trial  = '0;
		unique case (op_q)
			AR_MUL: begin
				if (y_q[0]) acc_nx = acc_q + x_q;
				x_nx = {x_q[126:0], 1'b0};
				y_nx = {1'b0, y_q[63:1]};
			end
			AR_DIV: begin
				r     = {2'b00, rem_q[64:0], x_q[63]};
				trial = {4'b0000, y_q};
				x_nx  = {x_q[126:0], 1'b0};
				if (r >= trial) begin
					rem_nx = r - trial;
					acc_nx = {acc_q[126:0], 1'b1};
				end else begin
					rem_nx = r;
					acc_nx = {acc_q[126:0], 1'b0};
				end
			end
			AR_SQRT: begin
				r     = {rem_q[65:0], x_q[127:126]};
				trial = {2'b00, acc_q[63:0], 2'b01};
				x_nx  = {x_q[125:0], 2'b00};
				if (r >= trial) begin
					rem_nx = r - trial;
					acc_nx = {acc_q[126:0], 1'b1};
				end else begin
					rem_nx = r;
					acc_nx = {acc_q[126:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= AR_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			acc_q <= '0;
			rem_q <= '0;
			y_q   <= b;
			x_q   <= (cmd.op == AR_SQRT) ? a : {64'd0, a[63:0]};
		end else if (busy_q) begin
			acc_q <= acc_nx;
			x_q   <= x_nx;
			y_q   <= y_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

>>> hdl/bms_back.sv
// back end: band store updates and finalization sequencer
module bms_back import bms_pkg::*; #(
	parameter int BANDS_MAX = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  op_t      q_op,
	output logic     q_pop,
	bms_res_if.source res
);

	localparam int AW = (BANDS_MAX > 1) ? $clog2(BANDS_MAX) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_DIVM, S_DIVMW, S_MULM, S_MULMW, S_RD, S_WR, S_FIN, S_FRD,
		S_SET, S_MA, S_MAW, S_MB, S_MBW, S_SQ, S_SQW, S_DM, S_DMW, S_DS,
		S_DSW, S_OUT, S_CLR
	} state_t;

	state_t       state_q;
	op_t          op_q;
	logic [63:0]  m_q;
	logic [63:0]  msq_q;
	logic [BP_W-1:0] k_q;
	logic [29:0]  n_q;
	logic [63:0]  s_q;
	logic [63:0]  sqa_q;
	logic [127:0] a_q;
	logic [63:0]  r_q;
	logic [63:0]  mean_q;

	// band store
	logic [63:0]  mem_sum [BANDS_MAX];
	logic [63:0]  mem_sq  [BANDS_MAX];
	logic [BANDS_MAX-1:0] vld_q;
	logic [63:0]  rd_sum_q;
	logic [63:0]  rd_sq_q;
	logic         rd_vld_q;

	// result register
	logic         rv_q;
	logic [5:0]   rb_q;
	logic [23:0]  rmean_q;
	logic [23:0]  rstd_q;
	logic [1:0]   rst_q;
	logic         rfin_q;

	arith_cmd_t   ar_cmd;
	arith_sts_t   ar_sts;
	logic [127:0] ar_a;
	logic [63:0]  ar_b;
	logic [127:0] ar_res;

	logic [AW-1:0] rd_addr;
	logic          mem_re;
	logic          mem_we;
	logic [63:0]   base_sum;
	logic [63:0]   base_sq;
	logic [29:0]   n_c;
	logic          out_load;
	logic          last_band;

	bms_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ar_cmd),
		.a      (ar_a),
		.b      (ar_b),
		.sts    (ar_sts),
		.res    (ar_res)
	);

	assign res.valid     = rv_q;
	assign res.band      = rb_q;
	assign res.mean_q8   = rmean_q;
	assign res.std_q8    = rstd_q;
	assign res.status    = rst_q;
	assign res.final_res = rfin_q;

	// operand selection for the shared unit
	always_comb begin
		ar_cmd.start = 1'b0;
		ar_cmd.op    = AR_MUL;
		ar_a         = '0;
		ar_b         = '0;
		unique case (state_q)
			S_DIVM: begin
				ar_cmd = '{start: 1'b1, op: AR_DIV};
				ar_a   = 128'({op_q.lbt, 8'd0});
				ar_b   = 64'(op_q.ns);
			end
			S_MULM: begin
				ar_cmd = '{start: 1'b1, op: AR_MUL};
				ar_a   = 128'(m_q);
				ar_b   = m_q;
			end
			S_MA: begin
				ar_cmd = '{start: 1'b1, op: AR_MUL};
				ar_a   = 128'(n_q);
				ar_b   = sqa_q;
			end
			S_MB: begin
				ar_cmd = '{start: 1'b1, op: AR_MUL};
				ar_a   = 128'(s_q);
				ar_b   = s_q;
			end
			S_SQ: begin
				ar_cmd = '{start: 1'b1, op: AR_SQRT};
				ar_a   = a_q;
			end
			S_DM: begin
				ar_cmd = '{start: 1'b1, op: AR_DIV};
				ar_a   = 128'(s_q);
				ar_b   = 64'(n_q);
			end
			S_DS: begin
				ar_cmd = '{start: 1'b1, op: AR_DIV};
				ar_a   = 128'(r_q);
				ar_b   = 64'(n_q);
			end
			default: ;
		endcase
	end

	// store access and misc decode
	always_comb begin
		q_pop     = (state_q == S_IDLE) && !q_empty;
		mem_re    = (state_q == S_RD) || (state_q == S_FRD);
		mem_we    = state_q == S_WR;
		rd_addr   = (state_q == S_RD) ? op_q.band[AW-1:0] : k_q[AW-1:0];
		base_sum  = rd_vld_q ? rd_sum_q : '0;
		base_sq   = rd_vld_q ? rd_sq_q : '0;
		n_c       = op_q.mode ? 30'(op_q.lc) : 30'(op_q.lc) * 30'(op_q.ns);
		out_load  = (state_q == S_OUT) && (!rv_q || res.ready);
		last_band = ({1'b0, k_q} + NB_W'(1)) == op_q.nb;
	end

	// band store memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_sum[op_q.band[AW-1:0]] <= base_sum + 64'(op_q.pix_sum) + m_q;
			mem_sq[op_q.band[AW-1:0]]  <= base_sq + 64'(op_q.pix_sq) + msq_q;
		end
		if (mem_re) begin
			rd_sum_q <= mem_sum[rd_addr];
			rd_sq_q  <= mem_sq[rd_addr];
		end
	end

	// entry valid bits, cleared together after a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_re) rd_vld_q <= vld_q[rd_addr];
			if (mem_we) vld_q[op_q.band[AW-1:0]] <= 1'b1;
			else if (state_q == S_CLR) vld_q <= '0;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			if (out_load) rv_q <= 1'b1;
			else if (rv_q && res.ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						op_q  <= q_op;
						m_q   <= '0;
						msq_q <= '0;
						if (q_op.do_acc) state_q <= q_op.frame ? S_DIVM : S_RD;
						else if (q_op.fin) state_q <= S_FIN;
					end
				end
				S_DIVM: state_q <= S_DIVMW;
				S_DIVMW: begin
					if (ar_sts.done) begin
						m_q     <= ar_res[63:0];
						state_q <= S_MULM;
					end
				end
				S_MULM: state_q <= S_MULMW;
				S_MULMW: begin
					if (ar_sts.done) begin
						msq_q   <= ar_res[63:0];
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= op_q.fin ? S_FIN : S_IDLE;
				S_FIN: begin
					k_q     <= '0;
					state_q <= (op_q.status != ST_OK) ? S_OUT : S_FRD;
				end
				S_FRD: state_q <= S_SET;
				S_SET: begin
					n_q   <= n_c;
					s_q   <= op_q.mode ? base_sum : {base_sum[55:0], 8'd0};
					sqa_q <= base_sq;
					if (n_c == '0) begin
						mean_q  <= '0;
						r_q     <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MAW;
				S_MAW: begin
					if (ar_sts.done) begin
						a_q     <= op_q.mode ? ar_res : {ar_res[111:0], 16'd0};
						state_q <= S_MB;
					end
				end
				S_MB: state_q <= S_MBW;
				S_MBW: begin
					if (ar_sts.done) begin
						if (ar_res <= a_q) begin
							a_q     <= a_q - ar_res;
							state_q <= S_SQ;
						end else begin
							r_q     <= '0;
							state_q <= S_DM;
						end
					end
				end
				S_SQ: state_q <= S_SQW;
				S_SQW: begin
					if (ar_sts.done) begin
						r_q     <= ar_res[63:0];
						state_q <= S_DM;
					end
				end
				S_DM: state_q <= S_DMW;
				S_DMW: begin
					if (ar_sts.done) begin
						mean_q  <= ar_res[63:0];
						state_q <= S_DS;
					end
				end
				S_DS: state_q <= S_DSW;
				S_DSW: begin
					if (ar_sts.done) begin
						r_q     <= ar_res[63:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (op_q.status != ST_OK) begin
							rb_q    <= '0;
							rmean_q <= '0;
							rstd_q  <= '0;
							rst_q   <= op_q.status;
							rfin_q  <= 1'b1;
							state_q <= S_CLR;
						end else begin
							rb_q    <= k_q;
							rmean_q <= (mean_q[63:24] != '0) ? Q8_MAX : mean_q[23:0];
							rstd_q  <= (r_q[63:24] != '0) ? Q8_MAX : r_q[23:0];
							rst_q   <= ST_OK;
							rfin_q  <= last_band;
							if (last_band) begin
								state_q <= S_CLR;
							end else begin
								k_q     <= k_q + BP_W'(1);
								state_q <= S_FRD;
							end
						end
					end
				end
				S_CLR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared unit is only started while free
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		ar_cmd.start |-> !ar_sts.busy)
		else $error("arith unit started while busy");

	// band loop stays inside the configured band count
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SET) |-> ({1'b0, k_q} < op_q.nb))
		else $error("band index past band count");

	// error results carry no statistics and close the run
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |->
		(res.final_res && res.mean_q8 == '0 && res.std_q8 == '0 && res.band == '0))
		else $error("malformed error result");

endmodule

>>> hdl/band_mean_std_accumulator.sv
// top level: configuration registers, front end, op queue and back end
//
// Per-band mean and standard deviation of a band-interleaved-by-line pixel stream.
// The front end takes one pixel per cycle as long as the four-entry op queue has room;
// it folds each band's run of samples into a segment sum and hands one op per band
// segment to the back end. In pixel mode the back end does a store read and a store
// write per op, in frame mode it first runs a divide for the line mean and a square in
// the shared iterative unit, so segments shorter than the back end's work per op stall
// input once the queue is full. The last pixel starts finalization: each band runs up
// to five multiply, square root and divide passes in the shared unit after a store
// read, results leave through an output register, and the band store is then cleared
// at once in the S_CLR state through per-entry valid bits, with no clearing pass.
module band_mean_std_accumulator import bms_pkg::*; #(
	parameter int BANDS_MAX   = 64,
	parameter int SAMPLES_MAX = 4096,
	parameter int LINES_MAX   = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	bms_pix_if.sink           pix,
	bms_res_if.source         res,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [NB_W-1:0] nb_q;
	logic [NS_W-1:0] ns_q;
	logic            mode_q;
	logic [NB_W-1:0] nb_eff;
	logic [NS_W-1:0] ns_eff;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	op_t  q_din;
	op_t  q_dout;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q   <= NB_W'(1);
			ns_q   <= NS_W'(1);
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_BANDS:   nb_q   <= cfg_data[NB_W-1:0];
				CFG_NUM_SAMPLES: ns_q   <= cfg_data[NS_W-1:0];
				CFG_STAT_MODE:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp counts to their usable range
	always_comb begin
		if (nb_q == '0) nb_eff = NB_W'(1);
		else if (nb_q > NB_W'(BANDS_MAX)) nb_eff = NB_W'(BANDS_MAX);
		else nb_eff = nb_q;
		if (ns_q == '0) ns_eff = NS_W'(1);
		else if (ns_q > NS_W'(SAMPLES_MAX)) ns_eff = NS_W'(SAMPLES_MAX);
		else ns_eff = ns_q;
	end

	bms_front #(
		.LINES_MAX (LINES_MAX)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.nb_eff (nb_eff),
		.ns_eff (ns_eff),
		.mode   (mode_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_din)
	);

	bms_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	bms_back #(
		.BANDS_MAX (BANDS_MAX)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_op    (q_dout),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
